### design/pure_pursuit_steering_core_defines.svh
// ----------------------------------------------------------------------------
// Pure pursuit steering core: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PURE_PURSUIT_STEERING_CORE_DEFINES_SVH
`define PURE_PURSUIT_STEERING_CORE_DEFINES_SVH

// same-cycle implication
`define PPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
  else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
  else $error(msg);

`endif

### design/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the pure pursuit steering modules.
// ----------------------------------------------------------------------------
package pps_pkg;

  // input item kinds
  localparam logic [1:0] FUNC_POINT = 2'd0;
  localparam logic [1:0] FUNC_POSE  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_LOOKAHEAD = 3'd0;
  localparam logic [2:0] CFG_LIN_VEL   = 3'd1;
  localparam logic [2:0] CFG_INTERP    = 3'd2;
  localparam logic [2:0] CFG_MAX_ANG   = 3'd3;
  localparam logic [2:0] CFG_MIN_ANG   = 3'd4;
  localparam logic [2:0] CFG_GOAL_TOL  = 3'd5;

  localparam int DIV_STEPS    = 32;
  localparam int CORDIC_STEPS = 14;
  localparam int CDIV_STEPS   = 68;

  localparam logic [15:0] CORDIC_GAIN = 16'd39797;
  localparam logic [63:0] L2_FLOOR    = 64'd429497;
  localparam logic [40:0] CURV_CAP    = 41'h100_0000_0000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_INTERP,
    ST_G_ISSUE, ST_G_WAIT, ST_N_SCAN, ST_N_WAIT, ST_L_SCAN, ST_L_WAIT,
    ST_T_ISSUE, ST_T_WAIT, ST_ROT_INIT, ST_ROT, ST_GAIN, ST_YREL,
    ST_CDIV, ST_VMUL, ST_FIN, ST_OUT
  } state_t;

  // what the distance pipe does with a finished distance
  typedef enum logic [1:0] {
    MODE_GOAL, MODE_NEAR, MODE_LOOK, MODE_TGT
  } mode_t;

  typedef struct packed {
    logic       load_first;
    logic       load_point;
    logic       div_step;
    logic       interp_step;
    logic       load_pose;
    logic       addr_clr;
    logic       addr_inc;
    logic       addr_last;
    logic       addr_target;
    logic       rd_en;
    mode_t      mode;
    logic       look_clr;
    logic       goal_clear;
    logic       res_zero;
    logic       rot_init;
    logic       rot_step;
    logic [3:0] step_idx;
    logic       gain_mul;
    logic       yrel_load;
    logic       cdiv_step;
    logic       vmul;
    logic       fin;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       path_empty;
    logic       route_done;
    logic       addr_at_last;
    logic       pipe_busy;
    logic       goal_hit;
    logic [6:0] n_eff;
    logic       out_full;
  } sts_t;

  // CORDIC angle table, binary angle units
  function automatic logic [13:0] atan_lut(input logic [3:0] idx);
    logic [13:0] v;
    case (idx)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

### design/pure_pursuit_steering_core.sv
// ----------------------------------------------------------------------------
// pure_pursuit_steering_core
// Path store and pure pursuit steering command generator.
// ----------------------------------------------------------------------------
// One item is worked at a time; in_stall stays high until it is done. A pose
// item and the first path point are absorbed without leaving idle; a later
// point runs a bit-serial 32-step divide for the step size, then one store
// write per interpolated point while the store has room. A tick on an empty
// or finished path loads a zero result into the output register. Any other
// tick checks the goal, then the single read port of the path memory feeds
// a 4-stage squared-distance pipe one point per cycle, once for the nearest
// point and once for the lookahead search, and then a 14-step CORDIC and a
// 68-step restoring divide for the curvature run. The result sits in an
// output register, so a new item is taken while it waits. The path memory
// holds no reset state and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "pure_pursuit_steering_core_defines.svh"

module pure_pursuit_steering_core #(
  parameter int PATH_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items: path points, poses, control ticks
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic [31:0] in_pose_x,
  input  logic [31:0] in_pose_y,
  input  logic [15:0] in_pose_heading,
  // result items, one per tick
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_linear_cmd,
  output logic [15:0] out_angular_cmd,
  output logic        out_goal_reached,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [30:0] cfg_wdata
);

  pps_pkg::cmd_t cmd;
  pps_pkg::sts_t sts;

  // sequencer
  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_func),
    .sts      (sts),
    .cmd      (cmd)
  );

  // path store, distance pipe, arithmetic and output register
  pps_dp #(
    .PATH_DEPTH (PATH_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_pose_x        (in_pose_x),
    .in_pose_y        (in_pose_y),
    .in_pose_heading  (in_pose_heading),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_linear_cmd   (out_linear_cmd),
    .out_angular_cmd  (out_angular_cmd),
    .out_goal_reached (out_goal_reached)
  );

  // accepted item of each kind
  logic acc_tick, acc_pose, acc_point;
  assign acc_tick  = in_valid && !in_stall && (in_func == pps_pkg::FUNC_TICK);
  assign acc_pose  = in_valid && !in_stall && (in_func == pps_pkg::FUNC_POSE);
  assign acc_point = in_valid && !in_stall && (in_func == pps_pkg::FUNC_POINT);

  // an accepted tick always occupies the block and keeps in_stall high
  `PPS_ASSERT_NXT(a_tick_busy, acc_tick, in_stall, "tick did not occupy the block")
  // a pose leaves the block free again in the next cycle
  `PPS_ASSERT_NXT(a_pose_quick, acc_pose, !in_stall, "pose item held the block")
  // after any accepted path point the path holds at least one point
  `PPS_ASSERT_NXT(a_point_stored, acc_point, !sts.path_empty, "path empty after a point")

endmodule

### design/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer: steps the datapath through point, pose and tick handling.
// ----------------------------------------------------------------------------
module pps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_func,
  input  pps_pkg::sts_t       sts,
  output pps_pkg::cmd_t       cmd
);

  pps_pkg::state_t state_r, state_nxt;
  logic [6:0]      cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pps_pkg::ST_IDLE;
      cnt_r   <= 7'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != pps_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = 7'd0;
    unique case (state_r)
      pps_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            pps_pkg::FUNC_POINT: if (!sts.path_empty) state_nxt = pps_pkg::ST_DIV;
            pps_pkg::FUNC_TICK: begin
              if (sts.path_empty || sts.route_done) state_nxt = pps_pkg::ST_OUT;
              else state_nxt = pps_pkg::ST_G_ISSUE;
            end
            default: state_nxt = pps_pkg::ST_IDLE;
          endcase
        end
      end
      pps_pkg::ST_DIV: begin
        if (cnt_r == 7'(pps_pkg::DIV_STEPS - 1)) state_nxt = pps_pkg::ST_INTERP;
        else cnt_nxt = cnt_r + 7'd1;
      end
      pps_pkg::ST_INTERP: begin
        if (cnt_r == sts.n_eff - 7'd1) state_nxt = pps_pkg::ST_IDLE;
        else cnt_nxt = cnt_r + 7'd1;
      end
      pps_pkg::ST_G_ISSUE: state_nxt = pps_pkg::ST_G_WAIT;
      pps_pkg::ST_G_WAIT: begin
        if (!sts.pipe_busy) begin
          state_nxt = sts.goal_hit ? pps_pkg::ST_OUT : pps_pkg::ST_N_SCAN;
        end
      end
      pps_pkg::ST_N_SCAN: if (sts.addr_at_last) state_nxt = pps_pkg::ST_N_WAIT;
      pps_pkg::ST_N_WAIT: if (!sts.pipe_busy) state_nxt = pps_pkg::ST_L_SCAN;
      pps_pkg::ST_L_SCAN: if (sts.addr_at_last) state_nxt = pps_pkg::ST_L_WAIT;
      pps_pkg::ST_L_WAIT: if (!sts.pipe_busy) state_nxt = pps_pkg::ST_T_ISSUE;
      pps_pkg::ST_T_ISSUE: state_nxt = pps_pkg::ST_T_WAIT;
      pps_pkg::ST_T_WAIT: if (!sts.pipe_busy) state_nxt = pps_pkg::ST_ROT_INIT;
      pps_pkg::ST_ROT_INIT: state_nxt = pps_pkg::ST_ROT;
      pps_pkg::ST_ROT: begin
        if (cnt_r == 7'(pps_pkg::CORDIC_STEPS - 1)) state_nxt = pps_pkg::ST_GAIN;
        else cnt_nxt = cnt_r + 7'd1;
      end
      pps_pkg::ST_GAIN: state_nxt = pps_pkg::ST_YREL;
      pps_pkg::ST_YREL: state_nxt = pps_pkg::ST_CDIV;
      pps_pkg::ST_CDIV: begin
        if (cnt_r == 7'(pps_pkg::CDIV_STEPS - 1)) state_nxt = pps_pkg::ST_VMUL;
        else cnt_nxt = cnt_r + 7'd1;
      end
      pps_pkg::ST_VMUL: state_nxt = pps_pkg::ST_FIN;
      pps_pkg::ST_FIN:  state_nxt = pps_pkg::ST_OUT;
      pps_pkg::ST_OUT:  if (!sts.out_full) state_nxt = pps_pkg::ST_IDLE;
      default: state_nxt = pps_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.mode     = pps_pkg::MODE_GOAL;
    cmd.step_idx = cnt_r[3:0];
    unique case (state_r)
      pps_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            pps_pkg::FUNC_POINT: begin
              cmd.load_first = sts.path_empty;
              cmd.load_point = !sts.path_empty;
            end
            pps_pkg::FUNC_POSE: cmd.load_pose = 1'b1;
            pps_pkg::FUNC_TICK: begin
              cmd.res_zero  = sts.path_empty || sts.route_done;
              cmd.addr_last = !(sts.path_empty || sts.route_done);
            end
            default: ;
          endcase
        end
      end
      pps_pkg::ST_DIV:    cmd.div_step    = 1'b1;
      pps_pkg::ST_INTERP: cmd.interp_step = 1'b1;
      pps_pkg::ST_G_ISSUE: cmd.rd_en = 1'b1;
      pps_pkg::ST_G_WAIT: begin
        if (!sts.pipe_busy) begin
          cmd.goal_clear = sts.goal_hit;
          cmd.addr_clr   = !sts.goal_hit;
        end
      end
      pps_pkg::ST_N_SCAN: begin
        cmd.mode     = pps_pkg::MODE_NEAR;
        cmd.rd_en    = 1'b1;
        cmd.addr_inc = 1'b1;
      end
      pps_pkg::ST_N_WAIT: begin
        cmd.mode     = pps_pkg::MODE_NEAR;
        cmd.addr_clr = !sts.pipe_busy;
        cmd.look_clr = !sts.pipe_busy;
      end
      pps_pkg::ST_L_SCAN: begin
        cmd.mode     = pps_pkg::MODE_LOOK;
        cmd.rd_en    = 1'b1;
        cmd.addr_inc = 1'b1;
      end
      pps_pkg::ST_L_WAIT: begin
        cmd.mode        = pps_pkg::MODE_LOOK;
        cmd.addr_target = !sts.pipe_busy;
      end
      pps_pkg::ST_T_ISSUE: begin
        cmd.mode  = pps_pkg::MODE_TGT;
        cmd.rd_en = 1'b1;
      end
      pps_pkg::ST_T_WAIT:   cmd.mode      = pps_pkg::MODE_TGT;
      pps_pkg::ST_ROT_INIT: cmd.rot_init  = 1'b1;
      pps_pkg::ST_ROT:      cmd.rot_step  = 1'b1;
      pps_pkg::ST_GAIN:     cmd.gain_mul  = 1'b1;
      pps_pkg::ST_YREL:     cmd.yrel_load = 1'b1;
      pps_pkg::ST_CDIV:     cmd.cdiv_step = 1'b1;
      pps_pkg::ST_VMUL:     cmd.vmul      = 1'b1;
      pps_pkg::ST_FIN:      cmd.fin       = 1'b1;
      pps_pkg::ST_OUT:      cmd.out_load  = !sts.out_full;
      default: ;
    endcase
  end

endmodule

### design/pps_dp.sv
// ----------------------------------------------------------------------------
// pps_dp
// Datapath: path store, distance pipe, dividers, CORDIC, result registers.
// ----------------------------------------------------------------------------
module pps_dp #(
  parameter int PATH_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pps_pkg::cmd_t      cmd,
  output pps_pkg::sts_t      sts,
  input  logic [31:0]        in_point_x,
  input  logic [31:0]        in_point_y,
  input  logic [31:0]        in_pose_x,
  input  logic [31:0]        in_pose_y,
  input  logic [15:0]        in_pose_heading,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [30:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_linear_cmd,
  output logic [15:0]        out_angular_cmd,
  output logic               out_goal_reached
);

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int LW = $clog2(PATH_DEPTH + 1);

  // ---------------- configuration ----------------
  logic [30:0] la_r, gt_r;
  logic [15:0] lv_r, maxw_r, minw_r;
  logic [6:0]  interp_r;
  logic [61:0] la2_r, gt2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r     <= 31'd32768;
      lv_r     <= 16'd51;
      interp_r <= 7'd10;
      maxw_r   <= 16'd256;
      minw_r   <= 16'hFF00;
      gt_r     <= 31'd9830;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pps_pkg::CFG_LOOKAHEAD: la_r     <= cfg_wdata;
        pps_pkg::CFG_LIN_VEL:   lv_r     <= cfg_wdata[15:0];
        pps_pkg::CFG_INTERP:    interp_r <= cfg_wdata[6:0];
        pps_pkg::CFG_MAX_ANG:   maxw_r   <= cfg_wdata[15:0];
        pps_pkg::CFG_MIN_ANG:   minw_r   <= cfg_wdata[15:0];
        pps_pkg::CFG_GOAL_TOL:  gt_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // squared thresholds, settled long before a tick reads them
  always_ff @(posedge clk) begin
    la2_r <= la_r * la_r;
    gt2_r <= gt_r * gt_r;
  end

  logic [6:0] n_eff;
  assign n_eff = (interp_r == 7'd0) ? 7'd1 : interp_r;

  // ---------------- path state ----------------
  logic [LW-1:0] len_r;
  logic          done_r;
  logic [31:0]   last_x_r, last_y_r;
  logic [31:0]   rob_x_r, rob_y_r;
  logic [15:0]   rob_h_r;
  logic          len_full;
  logic [LW-1:0] len_m1;

  assign len_full = (len_r == LW'(PATH_DEPTH));
  assign len_m1   = len_r - LW'(1);

  // interpolation dividers: magnitude in, quotient out in the same register
  logic [31:0] qx_r, qy_r;
  logic [6:0]  rx_r, ry_r;
  logic        negx_r, negy_r;
  logic [31:0] accx_r, accy_r;
  logic [32:0] diffx, diffy, magx, magy;
  logic [7:0]  shx, shy, dsub_x, dsub_y;
  logic        gex, gey;
  logic [31:0] accx_nxt, accy_nxt;

  always_comb begin
    diffx  = {in_point_x[31], in_point_x} - {last_x_r[31], last_x_r};
    diffy  = {in_point_y[31], in_point_y} - {last_y_r[31], last_y_r};
    magx   = diffx[32] ? -diffx : diffx;
    magy   = diffy[32] ? -diffy : diffy;
    shx    = {rx_r, qx_r[31]};
    shy    = {ry_r, qy_r[31]};
    gex    = (shx >= {1'b0, n_eff});
    gey    = (shy >= {1'b0, n_eff});
    dsub_x = shx - {1'b0, n_eff};
    dsub_y = shy - {1'b0, n_eff};
    accx_nxt = accx_r + (negx_r ? -qx_r : qx_r);
    accy_nxt = accy_r + (negy_r ? -qy_r : qy_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      qx_r   <= magx[31:0];
      qy_r   <= magy[31:0];
      rx_r   <= 7'd0;
      ry_r   <= 7'd0;
      negx_r <= diffx[32];
      negy_r <= diffy[32];
      accx_r <= last_x_r;
      accy_r <= last_y_r;
    end else if (cmd.div_step) begin
      qx_r <= {qx_r[30:0], gex};
      qy_r <= {qy_r[30:0], gey};
      rx_r <= gex ? dsub_x[6:0] : shx[6:0];
      ry_r <= gey ? dsub_y[6:0] : shy[6:0];
    end else if (cmd.interp_step) begin
      accx_r <= accx_nxt;
      accy_r <= accy_nxt;
    end
  end

  logic        mem_we;
  logic [31:0] wd_x, wd_y;
  assign mem_we = cmd.load_first || (cmd.interp_step && !len_full);
  assign wd_x   = cmd.load_first ? in_point_x : accx_nxt;
  assign wd_y   = cmd.load_first ? in_point_y : accy_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      done_r  <= 1'b0;
      rob_x_r <= '0;
      rob_y_r <= '0;
      rob_h_r <= '0;
    end else begin
      if (cmd.goal_clear) len_r <= '0;
      else if (cmd.load_first) len_r <= LW'(1);
      else if (mem_we) len_r <= len_r + LW'(1);
      if (cmd.goal_clear) done_r <= 1'b1;
      else if (cmd.load_point) done_r <= 1'b0;
      if (cmd.load_pose) begin
        rob_x_r <= in_pose_x;
        rob_y_r <= in_pose_y;
        rob_h_r <= in_pose_heading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      last_x_r <= wd_x;
      last_y_r <= wd_y;
    end
  end

  // ---------------- path memory ----------------
  logic [31:0]   mem_x [PATH_DEPTH];
  logic [31:0]   mem_y [PATH_DEPTH];
  logic [AW-1:0] addr_r;
  logic [31:0]   rdx_r, rdy_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[len_r[AW-1:0]] <= wd_x;
      mem_y[len_r[AW-1:0]] <= wd_y;
    end
    if (cmd.rd_en) begin
      rdx_r <= mem_x[addr_r];
      rdy_r <= mem_y[addr_r];
    end
  end

  // ---------------- distance pipe ----------------
  logic                 v0_r, v1_r, v2_r, v3_r;
  logic [AW-1:0]        i0_r, i1_r, i2_r, i3_r;
  logic signed [32:0]   dx1_r, dy1_r, dx2_r, dy2_r, dx3_r, dy3_r;
  logic [63:0]          sqx2_r, sqy2_r, d3_r;
  logic [32:0]          ax, ay;
  logic [64:0]          dsum;

  assign ax   = dx1_r[32] ? -dx1_r : dx1_r;
  assign ay   = dy1_r[32] ? -dy1_r : dy1_r;
  assign dsum = {1'b0, sqx2_r} + {1'b0, sqy2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= cmd.rd_en;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    i0_r   <= addr_r;
    i1_r   <= i0_r;
    i2_r   <= i1_r;
    i3_r   <= i2_r;
    dx1_r  <= {rdx_r[31], rdx_r} - {rob_x_r[31], rob_x_r};
    dy1_r  <= {rdy_r[31], rdy_r} - {rob_y_r[31], rob_y_r};
    dx2_r  <= dx1_r;
    dy2_r  <= dy1_r;
    sqx2_r <= ax[31:0] * ax[31:0];
    sqy2_r <= ay[31:0] * ay[31:0];
    dx3_r  <= dx2_r;
    dy3_r  <= dy2_r;
    d3_r   <= dsum[64] ? {64{1'b1}} : dsum[63:0];
  end

  // scan bookkeeping
  logic          goal_hit_r, found_r;
  logic [63:0]   best_r, l2_r;
  logic [AW-1:0] near_r, tgt_r;
  logic signed [32:0] dxt_r, dyt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_hit_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      if (cmd.look_clr) found_r <= 1'b0;
      if (v3_r) begin
        case (cmd.mode)
          pps_pkg::MODE_GOAL: goal_hit_r <= (d3_r <= {2'b0, gt2_r});
          pps_pkg::MODE_LOOK: begin
            if (!found_r && (i3_r > near_r) && (d3_r >= {2'b0, la2_r})) found_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r) begin
      case (cmd.mode)
        pps_pkg::MODE_NEAR: begin
          if ((i3_r == '0) || (d3_r < best_r)) begin
            best_r <= d3_r;
            near_r <= i3_r;
          end
        end
        pps_pkg::MODE_LOOK: begin
          if (!found_r && (i3_r > near_r) && (d3_r >= {2'b0, la2_r})) tgt_r <= i3_r;
        end
        pps_pkg::MODE_TGT: begin
          dxt_r <= dx3_r;
          dyt_r <= dy3_r;
          l2_r  <= (d3_r < pps_pkg::L2_FLOOR) ? pps_pkg::L2_FLOOR : d3_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_clr) addr_r <= '0;
    else if (cmd.addr_inc) addr_r <= addr_r + AW'(1);
    else if (cmd.addr_last) addr_r <= len_m1[AW-1:0];
    else if (cmd.addr_target) addr_r <= found_r ? tgt_r : len_m1[AW-1:0];
  end

  // ---------------- CORDIC rotation by minus heading ----------------
  logic signed [35:0] cx_r, cy_r, cxs, cys;
  logic signed [17:0] cz_r, z0, z1;
  logic signed [17:0] at;
  logic               flip;

  always_comb begin
    z0 = -$signed({{2{rob_h_r[15]}}, rob_h_r});
    if (z0 > 18'sd32767) z0 = z0 - 18'sd65536;
    flip = 1'b0;
    z1   = z0;
    if (z0 > 18'sd16384) begin
      flip = 1'b1;
      z1   = z0 - 18'sd32768;
    end else if (z0 < -18'sd16384) begin
      flip = 1'b1;
      z1   = z0 + 18'sd32768;
    end
    cxs = cx_r >>> cmd.step_idx;
    cys = cy_r >>> cmd.step_idx;
    at  = $signed({4'b0, pps_pkg::atan_lut(cmd.step_idx)});
  end

  always_ff @(posedge clk) begin
    if (cmd.rot_init) begin
      cx_r <= flip ? -36'(dxt_r) : 36'(dxt_r);
      cy_r <= flip ? -36'(dyt_r) : 36'(dyt_r);
      cz_r <= z1;
    end else if (cmd.rot_step) begin
      if (cz_r >= 18'sd0) begin
        cx_r <= cx_r - cys;
        cy_r <= cy_r + cxs;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + cys;
        cy_r <= cy_r - cxs;
        cz_r <= cz_r + at;
      end
    end
  end

  // ---------------- gain, curvature division, speed product ----------------
  logic signed [52:0] gprod_r;
  logic signed [36:0] yrel;
  logic [36:0]        ymag;
  logic               yneg_r;
  logic [67:0]        cq_r;
  logic [63:0]        crem_r;
  logic [64:0]        csh, csub;
  logic               cge;
  logic [40:0]        curv;
  logic [15:0]        vabs;
  logic [56:0]        vprod_r;

  assign yrel = gprod_r[52:16];
  assign ymag = yrel[36] ? -yrel : yrel;
  assign csh  = {crem_r, cq_r[67]};
  assign csub = csh - {1'b0, l2_r};
  assign cge  = (csh >= {1'b0, l2_r});
  assign curv = (cq_r > 68'(pps_pkg::CURV_CAP)) ? pps_pkg::CURV_CAP : cq_r[40:0];
  assign vabs = lv_r[15] ? -lv_r : lv_r;

  always_ff @(posedge clk) begin
    if (cmd.gain_mul) gprod_r <= cy_r * $signed({1'b0, pps_pkg::CORDIC_GAIN});
    if (cmd.yrel_load) begin
      yneg_r <= yrel[36];
      cq_r   <= {ymag[34:0], 33'b0};
      crem_r <= '0;
    end else if (cmd.cdiv_step) begin
      cq_r   <= {cq_r[66:0], cge};
      crem_r <= cge ? csub[63:0] : csh[63:0];
    end
    if (cmd.vmul) vprod_r <= curv * vabs;
  end

  // ---------------- sign, saturation and clamps ----------------
  logic [40:0]        mag;
  logic [16:0]        magc;
  logic signed [17:0] w0, w1, w2, w3, minw, maxw;

  always_comb begin
    mag  = vprod_r[56:16];
    magc = (mag > 41'd32768) ? 17'd32768 : mag[16:0];
    w0   = (yneg_r ^ lv_r[15]) ? -$signed({1'b0, magc}) : $signed({1'b0, magc});
    minw = $signed({{2{minw_r[15]}}, minw_r});
    maxw = $signed({{2{maxw_r[15]}}, maxw_r});
    w1   = (w0 > 18'sd32767) ? 18'sd32767 : w0;
    w2   = (w1 < minw) ? minw : w1;
    w3   = (w2 > maxw) ? maxw : w2;
  end

  logic [15:0] res_lin_r, res_ang_r;
  logic        res_goal_r;

  always_ff @(posedge clk) begin
    if (cmd.res_zero || cmd.goal_clear) begin
      res_lin_r  <= '0;
      res_ang_r  <= '0;
      res_goal_r <= cmd.goal_clear;
    end else if (cmd.fin) begin
      res_lin_r  <= lv_r;
      res_ang_r  <= w3[15:0];
      res_goal_r <= 1'b0;
    end
  end

  // ---------------- output register ----------------
  logic        out_valid_r;
  logic [15:0] out_lin_r, out_ang_r;
  logic        out_goal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_lin_r  <= res_lin_r;
      out_ang_r  <= res_ang_r;
      out_goal_r <= res_goal_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_linear_cmd   = out_lin_r;
  assign out_angular_cmd  = out_ang_r;
  assign out_goal_reached = out_goal_r;

  always_comb begin
    sts.path_empty   = (len_r == '0);
    sts.route_done   = done_r;
    sts.addr_at_last = (LW'(addr_r) == len_m1);
    sts.pipe_busy    = v0_r | v1_r | v2_r | v3_r;
    sts.goal_hit     = goal_hit_r;
    sts.n_eff        = n_eff;
    sts.out_full     = out_valid_r && out_stall;
  end

endmodule
